>>> rtl/smcp_pkg.sv
// Shared types and constants for the serial motor command parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package smcp_pkg;

  localparam int LINE_LIMIT_DEF = 49;

  localparam int CH_W    = 8;
  localparam int VAL_W   = 8;
  localparam int ACC_W   = 12;
  localparam int OC_W    = 3;
  localparam int CIDX_W  = 2;
  localparam int LV_W    = 14;
  localparam int OUT_W   = 24;

  localparam logic [ACC_W-1:0] ACC_MAX = 12'd4095;

  localparam logic [VAL_W-1:0] MOTOR_LIMIT_RST = 8'd255;
  localparam logic [VAL_W-1:0] SERVO_MIN_RST   = 8'd45;
  localparam logic [VAL_W-1:0] SERVO_MAX_RST   = 8'd135;
  localparam logic [VAL_W-1:0] SERVO_HOME_RST  = 8'd90;

  localparam logic [CH_W-1:0] CH_NL    = 8'd10;
  localparam logic [CH_W-1:0] CH_NUL   = 8'd0;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_MOTOR_LIMIT = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SERVO_MIN   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_SERVO_MAX   = 2'd2;
  localparam logic [CIDX_W-1:0] REG_SERVO_HOME  = 2'd3;

  // outcome codes
  localparam logic [OC_W-1:0] OC_IGNORED  = 3'd0;
  localparam logic [OC_W-1:0] OC_ENGAGED  = 3'd1;
  localparam logic [OC_W-1:0] OC_MOTOR    = 3'd2;
  localparam logic [OC_W-1:0] OC_SERVO    = 3'd3;
  localparam logic [OC_W-1:0] OC_STATUS   = 3'd4;
  localparam logic [OC_W-1:0] OC_RESET    = 3'd5;
  localparam logic [OC_W-1:0] OC_UNPARSED = 3'd6;

  // keyword bits
  localparam int KW_ENGAGE = 0;
  localparam int KW_DC     = 1;
  localparam int KW_SERVO  = 2;
  localparam int KW_STATUS = 3;
  localparam int KW_RESET  = 4;

  // marker / accumulator bits
  localparam int MK_PLUS  = 0;
  localparam int MK_MINUS = 1;
  localparam int MK_DIGIT = 2;

  typedef struct packed {
    logic [4:0]       kw_seen;
    logic [2:0]       marker;
    logic [ACC_W-1:0] acc_plus;
    logic [ACC_W-1:0] acc_minus;
    logic [ACC_W-1:0] acc_digit;
  } line_info_t;

  typedef struct packed {
    logic [OC_W-1:0]  outcome;
    logic [VAL_W-1:0] motor;
    logic [VAL_W-1:0] servo;
    logic             armed;
  } judge_res_t;

endpackage

>>> rtl/smcp_scan.sv
// Line scanner: keyword window, sign markers, digit accumulators, length cut.
// Depends on smcp_pkg.
`timescale 1ns / 1ps

module smcp_scan import smcp_pkg::*; #(
  parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [CH_W-1:0] ch,
  output line_info_t      info
);

  localparam int LEN_W = $clog2(LINE_LIMIT + 1);

  logic [CH_W-1:0]  recent_r [5];
  logic [CH_W-1:0]  recent_nxt [5];
  logic [4:0]       kw_r, kw_nxt;
  logic [2:0]       mk_r, mk_nxt;
  logic [2:0]       act_r, act_nxt;
  logic [ACC_W-1:0] acc_r [3];
  logic [ACC_W-1:0] acc_nxt [3];
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             cut_r, cut_nxt;

  logic [CH_W-1:0]  lc;
  logic             isd;
  logic [3:0]       digit;

  function automatic logic [ACC_W-1:0] acc_step(input logic [ACC_W-1:0] a,
                                                input logic [3:0] d);
    logic [ACC_W+3:0] v;
    v = ({4'd0, a} << 3) + ({4'd0, a} << 1) + {{ACC_W{1'b0}}, d};
    acc_step = (v > {4'd0, ACC_MAX}) ? ACC_MAX : v[ACC_W-1:0];
  endfunction

  assign lc    = (ch >= 8'h41 && ch <= 8'h5A) ? ch + 8'd32 : ch;
  assign isd   = (ch >= 8'h30 && ch <= 8'h39);
  assign digit = 4'(ch - 8'h30);

  always_comb begin
    recent_nxt = recent_r;
    kw_nxt     = kw_r;
    mk_nxt     = mk_r;
    act_nxt    = act_r;
    acc_nxt    = acc_r;
    len_nxt    = len_r;
    cut_nxt    = cut_r;
    if (fire) begin
      if (ch == CH_NL) begin
        for (int i = 0; i < 5; i++) recent_nxt[i] = '0;
        kw_nxt  = '0;
        mk_nxt  = '0;
        act_nxt = '0;
        for (int i = 0; i < 3; i++) acc_nxt[i] = '0;
        len_nxt = '0;
        cut_nxt = 1'b0;
      end else if (!cut_r) begin
        if (ch == CH_NUL || len_r >= LEN_W'(LINE_LIMIT)) begin
          cut_nxt = 1'b1;
        end else begin
          len_nxt = len_r + 1'b1;
          // window compares, newest character first
          if (lc == "e" && recent_r[0] == "g" && recent_r[1] == "a" &&
              recent_r[2] == "g" && recent_r[3] == "n" && recent_r[4] == "e")
            kw_nxt[KW_ENGAGE] = 1'b1;
          if (lc == "c" && recent_r[0] == "d")
            kw_nxt[KW_DC] = 1'b1;
          if (lc == "o" && recent_r[0] == "v" && recent_r[1] == "r" &&
              recent_r[2] == "e" && recent_r[3] == "s")
            kw_nxt[KW_SERVO] = 1'b1;
          if (lc == "s" && recent_r[0] == "u" && recent_r[1] == "t" &&
              recent_r[2] == "a" && recent_r[3] == "t" && recent_r[4] == "s")
            kw_nxt[KW_STATUS] = 1'b1;
          if (lc == "t" && recent_r[0] == "e" && recent_r[1] == "s" &&
              recent_r[2] == "e" && recent_r[3] == "r")
            kw_nxt[KW_RESET] = 1'b1;

          for (int k = 0; k < 3; k++) begin
            if (act_r[k]) begin
              if (isd) acc_nxt[k] = acc_step(acc_r[k], digit);
              else act_nxt[k] = 1'b0;
            end
          end
          if (ch == CH_PLUS && !mk_r[MK_PLUS]) begin
            mk_nxt[MK_PLUS]  = 1'b1;
            act_nxt[MK_PLUS] = 1'b1;
            acc_nxt[MK_PLUS] = '0;
          end
          if (ch == CH_MINUS && !mk_r[MK_MINUS]) begin
            mk_nxt[MK_MINUS]  = 1'b1;
            act_nxt[MK_MINUS] = 1'b1;
            acc_nxt[MK_MINUS] = '0;
          end
          if (isd && !mk_r[MK_DIGIT]) begin
            mk_nxt[MK_DIGIT]  = 1'b1;
            act_nxt[MK_DIGIT] = 1'b1;
            acc_nxt[MK_DIGIT] = {{(ACC_W-4){1'b0}}, digit};
          end

          for (int i = 4; i > 0; i--) recent_nxt[i] = recent_r[i-1];
          recent_nxt[0] = lc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) recent_r[i] <= '0;
      kw_r  <= '0;
      mk_r  <= '0;
      act_r <= '0;
      for (int i = 0; i < 3; i++) acc_r[i] <= '0;
      len_r <= '0;
      cut_r <= 1'b0;
    end else begin
      recent_r <= recent_nxt;
      kw_r     <= kw_nxt;
      mk_r     <= mk_nxt;
      act_r    <= act_nxt;
      acc_r    <= acc_nxt;
      len_r    <= len_nxt;
      cut_r    <= cut_nxt;
    end
  end

  assign info.kw_seen   = kw_r;
  assign info.marker    = mk_r;
  assign info.acc_plus  = acc_r[MK_PLUS];
  assign info.acc_minus = acc_r[MK_MINUS];
  assign info.acc_digit = acc_r[MK_DIGIT];

endmodule

>>> rtl/smcp_judge.sv
// Line judgement: command priority, value selection and clamping.
// Depends on smcp_pkg.
`timescale 1ns / 1ps

module smcp_judge import smcp_pkg::*; (
  input  line_info_t       info,
  input  logic             armed,
  input  logic [VAL_W-1:0] motor,
  input  logic [VAL_W-1:0] servo,
  input  logic [VAL_W-1:0] motor_limit,
  input  logic [VAL_W-1:0] servo_min,
  input  logic [VAL_W-1:0] servo_max,
  input  logic [VAL_W-1:0] servo_home,
  output judge_res_t       res
);

  logic signed [LV_W-1:0] m_val, s_val;

  function automatic logic signed [LV_W-1:0] line_value(input logic [VAL_W-1:0] cur,
                                                       input line_info_t li);
    logic signed [LV_W-1:0] c;
    c = $signed({{(LV_W-VAL_W){1'b0}}, cur});
    if (li.marker[MK_PLUS])
      line_value = c + $signed({{(LV_W-ACC_W){1'b0}}, li.acc_plus});
    else if (li.marker[MK_MINUS])
      line_value = c - $signed({{(LV_W-ACC_W){1'b0}}, li.acc_minus});
    else if (li.marker[MK_DIGIT])
      line_value = $signed({{(LV_W-ACC_W){1'b0}}, li.acc_digit});
    else
      line_value = c;
  endfunction

  assign m_val = line_value(motor, info);
  assign s_val = line_value(servo, info);

  always_comb begin
    res.outcome = OC_IGNORED;
    res.motor   = motor;
    res.servo   = servo;
    res.armed   = armed;
    if (!armed) begin
      if (info.kw_seen[KW_ENGAGE]) begin
        res.armed   = 1'b1;
        res.outcome = OC_ENGAGED;
      end
    end else if (info.kw_seen[KW_DC]) begin
      res.outcome = OC_MOTOR;
      if (m_val > $signed({{(LV_W-VAL_W){1'b0}}, motor_limit}))
        res.motor = motor_limit;
      else if (m_val < 0)
        res.motor = '0;
      else
        res.motor = m_val[VAL_W-1:0];
    end else if (info.kw_seen[KW_SERVO]) begin
      res.outcome = OC_SERVO;
      if (s_val > $signed({{(LV_W-VAL_W){1'b0}}, servo_max}))
        res.servo = servo_max;
      else if (s_val < $signed({{(LV_W-VAL_W){1'b0}}, servo_min}))
        res.servo = servo_min;
      else
        res.servo = s_val[VAL_W-1:0];
    end else if (info.kw_seen[KW_STATUS]) begin
      res.outcome = OC_STATUS;
    end else if (info.kw_seen[KW_RESET]) begin
      res.outcome = OC_RESET;
      res.motor   = '0;
      res.servo   = servo_home;
    end else begin
      res.outcome = OC_UNPARSED;
    end
  end

endmodule

>>> rtl/serial_motor_command_parser.sv
// Serial motor command parser: one character per cycle, one result per newline.
// A newline passes the input stage register, then the output register, to out_*.
// Throughput: one character per cycle; the input stage stalls only when a
// newline meets a held, untaken result in the output register.
// Reset (rst_n low, synchronous): unarmed, motor 0, servo 90, line state cleared,
// configuration registers back to 255/45/135/90.
`timescale 1ns / 1ps

module serial_motor_command_parser import smcp_pkg::*; #(
  parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CH_W-1:0]   in_tdata,   // [7:0] ch
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // [2:0] outcome, [10:3] motor_speed,
                                        // [18:11] servo_angle, [19] armed
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]  cfg_data
);

  logic [VAL_W-1:0] motor_limit_r, servo_min_r, servo_max_r, servo_home_r;

  logic             s_valid_r;
  logic [CH_W-1:0]  s_ch_r;
  logic             s_nl, s_fire;

  logic             armed_r;
  logic [VAL_W-1:0] motor_r, servo_r;

  logic             out_valid_r;
  judge_res_t       out_r;

  line_info_t       info;
  judge_res_t       res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_limit_r <= MOTOR_LIMIT_RST;
      servo_min_r   <= SERVO_MIN_RST;
      servo_max_r   <= SERVO_MAX_RST;
      servo_home_r  <= SERVO_HOME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MOTOR_LIMIT: motor_limit_r <= cfg_data;
        REG_SERVO_MIN:   servo_min_r   <= cfg_data;
        REG_SERVO_MAX:   servo_max_r   <= cfg_data;
        REG_SERVO_HOME:  servo_home_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_nl      = (s_ch_r == CH_NL);
  assign s_fire    = s_valid_r && (!s_nl || !out_valid_r || out_tready);
  assign in_tready = !s_valid_r || s_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_tready) begin
      s_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) s_ch_r <= in_tdata;
  end

  smcp_scan #(
    .LINE_LIMIT(LINE_LIMIT)
  ) u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (s_fire),
    .ch   (s_ch_r),
    .info (info)
  );

  smcp_judge u_judge (
    .info       (info),
    .armed      (armed_r),
    .motor      (motor_r),
    .servo      (servo_r),
    .motor_limit(motor_limit_r),
    .servo_min  (servo_min_r),
    .servo_max  (servo_max_r),
    .servo_home (servo_home_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      motor_r <= '0;
      servo_r <= SERVO_HOME_RST;
    end else if (s_fire && s_nl) begin
      armed_r <= res.armed;
      motor_r <= res.motor;
      servo_r <= res.servo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s_fire && s_nl) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && s_nl) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_r.armed, out_r.servo, out_r.motor, out_r.outcome};

`ifndef SYNTHESIS
  a_armed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |=> armed_r)
    else $error("armed flag dropped");

  a_unarmed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.armed) |-> (out_r.outcome == OC_IGNORED))
    else $error("command outcome while unarmed");

  a_motor_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.outcome == OC_MOTOR) |-> (out_r.motor <= motor_limit_r))
    else $error("motor above limit");

  a_servo_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.outcome == OC_SERVO) |->
      (out_r.servo <= servo_max_r || out_r.servo == servo_min_r))
    else $error("servo outside clamp");

  a_stage_free: assert property (@(posedge clk) disable iff (!rst_n)
    !s_valid_r |-> in_tready)
    else $error("empty input stage not ready");
`endif

endmodule

>>> tb/serial_motor_command_parser_tb.sv
// Testbench for serial_motor_command_parser: random and directed command lines,
// checked against a behavioral model of the parser kept in this file.
// Depends on rtl/smcp_pkg.sv and rtl/serial_motor_command_parser.sv.
`timescale 1ns / 1ps

module serial_motor_command_parser_tb;
  import smcp_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_PCT      = 28;
  localparam int CALM_FROM     = 1200;
  localparam int CALM_TO       = 2200;
  localparam int SETTLE_CYCLES = 5;
  localparam int PHASE_CHARS   = 285;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [CH_W-1:0]   in_tdata   = '0;   // [7:0] ch
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;         // [2:0] outcome, [10:3] motor_speed,
                                        // [18:11] servo_angle, [19] armed
  logic              cfg_we     = 1'b0;
  logic [CIDX_W-1:0] cfg_index  = REG_MOTOR_LIMIT;
  logic [VAL_W-1:0]  cfg_data   = '0;

  serial_motor_command_parser #(.LINE_LIMIT(LINE_LIMIT_DEF)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // configuration copy
  logic [7:0] lim_motor, min_servo, max_servo, home_servo;

  // parser state copy
  logic       armed_q;
  logic [7:0] motor_q, servo_q;
  logic [7:0] win [5];
  logic [4:0] kw_q;
  logic [2:0] mk_q, act_q;
  int         acc_q [3];
  int         len_q;
  logic       cut_q;

  judge_res_t verdict_q [$];
  logic [7:0] char_q [$];
  int         chars_sent  = 0;
  int         chars_taken = 0;
  int         errors      = 0;
  int         cycle_no    = 0;
  int         dead_cycles = 0;
  int         hold_left   = 0;
  int         taken       = 0;
  logic       calm;

  assign calm = cycle_no >= CALM_FROM && cycle_no < CALM_TO;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic clear_line_state();
    int k;
    for (k = 0; k < 5; k++) win[k] = '0;
    for (k = 0; k < 3; k++) acc_q[k] = 0;
    kw_q  = '0;
    mk_q  = '0;
    act_q = '0;
    len_q = 0;
    cut_q = 1'b0;
  endtask

  function automatic logic tail_matches(string kw, logic [7:0] lc);
    int n;
    int k;
    n = kw.len();
    if (kw[n-1] != lc) return 1'b0;
    for (k = 1; k < n; k++)
      if (win[k-1] != kw[n-1-k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int line_amount(int cur);
    if (mk_q[MK_PLUS])  return cur + acc_q[MK_PLUS];
    if (mk_q[MK_MINUS]) return cur - acc_q[MK_MINUS];
    if (mk_q[MK_DIGIT]) return acc_q[MK_DIGIT];
    return cur;
  endfunction

  // update the parser copy with one accepted character
  task automatic track_char(input logic [7:0] c);
    logic [7:0] lc;
    logic       isd;
    int         v, lo, hi, k;
    judge_res_t r;
    if (c == CH_NL) begin
      r.outcome = OC_IGNORED;
      if (!armed_q) begin
        if (kw_q[KW_ENGAGE]) begin
          armed_q   = 1'b1;
          r.outcome = OC_ENGAGED;
        end
      end else if (kw_q[KW_DC]) begin
        hi = int'(lim_motor);
        v  = line_amount(int'(motor_q));
        if (v > hi) v = hi;
        else if (v < 0) v = 0;
        motor_q   = v[7:0];
        r.outcome = OC_MOTOR;
      end else if (kw_q[KW_SERVO]) begin
        hi = int'(max_servo);
        lo = int'(min_servo);
        v  = line_amount(int'(servo_q));
        if (v > hi) v = hi;
        else if (v < lo) v = lo;
        servo_q   = v[7:0];
        r.outcome = OC_SERVO;
      end else if (kw_q[KW_STATUS]) begin
        r.outcome = OC_STATUS;
      end else if (kw_q[KW_RESET]) begin
        motor_q   = '0;
        servo_q   = home_servo;
        r.outcome = OC_RESET;
      end else begin
        r.outcome = OC_UNPARSED;
      end
      clear_line_state();
      r.motor = motor_q;
      r.servo = servo_q;
      r.armed = armed_q;
      verdict_q.push_back(r);
    end else if (!cut_q) begin
      if (c == CH_NUL || len_q >= LINE_LIMIT_DEF) begin
        cut_q = 1'b1;
      end else begin
        len_q++;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (tail_matches("engage", lc)) kw_q[KW_ENGAGE] = 1'b1;
        if (tail_matches("dc", lc))     kw_q[KW_DC]     = 1'b1;
        if (tail_matches("servo", lc))  kw_q[KW_SERVO]  = 1'b1;
        if (tail_matches("status", lc)) kw_q[KW_STATUS] = 1'b1;
        if (tail_matches("reset", lc))  kw_q[KW_RESET]  = 1'b1;
        isd = c >= "0" && c <= "9";
        for (k = 0; k < 3; k++) begin
          if (act_q[k]) begin
            if (isd) begin
              v = acc_q[k] * 10 + int'(c - "0");
              acc_q[k] = (v > int'(ACC_MAX)) ? int'(ACC_MAX) : v;
            end else begin
              act_q[k] = 1'b0;
            end
          end
        end
        if (c == CH_PLUS && !mk_q[MK_PLUS]) begin
          mk_q[MK_PLUS]    = 1'b1;
          act_q[MK_PLUS]   = 1'b1;
          acc_q[MK_PLUS]   = 0;
        end
        if (c == CH_MINUS && !mk_q[MK_MINUS]) begin
          mk_q[MK_MINUS]   = 1'b1;
          act_q[MK_MINUS]  = 1'b1;
          acc_q[MK_MINUS]  = 0;
        end
        if (isd && !mk_q[MK_DIGIT]) begin
          mk_q[MK_DIGIT]   = 1'b1;
          act_q[MK_DIGIT]  = 1'b1;
          acc_q[MK_DIGIT]  = int'(c - "0");
        end
        for (k = 4; k > 0; k--) win[k] = win[k-1];
        win[0] = lc;
      end
    end
  endtask

  // ---------------- stimulus helpers ----------------

  task automatic add_byte(input logic [7:0] b);
    char_q.push_back(b);
    chars_sent++;
  endtask

  task automatic add_raw(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // keyword text with random letter case
  task automatic add_word(input string s);
    int         i;
    logic [7:0] b;
    for (i = 0; i < s.len(); i++) begin
      b = s[i];
      if (b >= "a" && b <= "z" && $urandom_range(1) == 1) b = b - 8'd32;
      add_byte(b);
    end
  endtask

  task automatic add_noise(input int n);
    string pool;
    int    i;
    pool = " +-0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.,:";
    for (i = 0; i < n; i++) add_byte(pool[$urandom_range(pool.len() - 1)]);
  endtask

  task automatic add_digits(input int n);
    int i;
    for (i = 0; i < n; i++) add_byte(8'("0" + $urandom_range(9)));
  endtask

  function automatic string pick_keyword();
    case ($urandom_range(9))
      0, 1, 2: return "dc";
      3, 4, 5: return "servo";
      6:       return "status";
      7:       return "reset";
      8:       return "engage";
      default: return "";
    endcase
  endfunction

  task automatic add_number();
    int n;
    n = ($urandom_range(19) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
    case ($urandom_range(9))
      0, 1, 2: begin add_byte(CH_PLUS);  add_digits(n); end
      3, 4, 5: begin add_byte(CH_MINUS); add_digits(n); end
      6, 7:    add_digits(n);
      8:       add_byte($urandom_range(1) ? CH_PLUS : CH_MINUS);
      default: ;
    endcase
  endtask

  task automatic add_random_line();
    int kind, n, i;
    kind = $urandom_range(99);
    if (kind < 50) begin
      if ($urandom_range(1)) add_noise($urandom_range(1, 2));
      add_word(pick_keyword());
      if ($urandom_range(1)) add_byte(" ");
      add_number();
      if ($urandom_range(3) == 0) add_noise($urandom_range(1, 2));
    end else if (kind < 62) begin
      add_word(pick_keyword());
      add_byte(" ");
      add_word(pick_keyword());
      add_byte(" ");
      add_number();
    end else if (kind < 72) begin
      n = $urandom_range(40, 75);
      i = $urandom_range(n);
      add_noise(i);
      add_word(pick_keyword());
      add_number();
      add_noise(n - i);
    end else if (kind < 80) begin
      add_word(pick_keyword());
      add_number();
      add_byte(CH_NUL);
      add_noise($urandom_range(3));
      add_word(pick_keyword());
      add_number();
    end else if (kind < 92) begin
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++)
        add_byte(8'($urandom_range(11, 255) - $urandom_range(1) * 11));
    end else begin
      add_noise($urandom_range(1));
    end
    add_byte(CH_NL);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_MOTOR_LIMIT: lim_motor  = val;
      REG_SERVO_MIN:   min_servo  = val;
      REG_SERVO_MAX:   max_servo  = val;
      REG_SERVO_HOME:  home_servo = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [7:0] lim, input logic [7:0] smin,
                               input logic [7:0] smax, input logic [7:0] shome);
    write_reg(REG_MOTOR_LIMIT, lim);
    write_reg(REG_SERVO_MIN, smin);
    write_reg(REG_SERVO_MAX, smax);
    write_reg(REG_SERVO_HOME, shome);
  endtask

  task automatic wait_drained();
    while (chars_taken != chars_sent || verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------- main sequence ----------------

  initial begin
    int p;
    int phase_end;
    lim_motor  = MOTOR_LIMIT_RST;
    min_servo  = SERVO_MIN_RST;
    max_servo  = SERVO_MAX_RST;
    home_servo = SERVO_HOME_RST;
    armed_q    = 1'b0;
    motor_q    = '0;
    servo_q    = SERVO_HOME_RST;
    clear_line_state();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // unarmed: engage hidden behind NUL, then engage, sign without digits
    add_raw("q");
    add_byte(8'hFF);
    add_byte(CH_NUL);
    add_raw("engage\n");
    add_raw("EnGaGe\n");
    add_raw("dc-\n");
    add_raw("SERVO-7\n");
    wait_drained();

    for (p = 0; p < 6; p++) begin
      case (p)
        0:       apply_setting(8'd255, 8'd0, 8'd180, 8'd180);
        1:       apply_setting(8'd0, 8'd180, 8'd0, 8'd0);
        2:       apply_setting(8'd100, 8'd45, 8'd135, 8'd0);
        5:       apply_setting(MOTOR_LIMIT_RST, SERVO_MIN_RST, SERVO_MAX_RST,
                               SERVO_HOME_RST);
        default: apply_setting(8'($urandom_range(255)), 8'($urandom_range(180)),
                               8'($urandom_range(180)), 8'($urandom_range(180)));
      endcase
      phase_end = chars_sent + PHASE_CHARS;
      while (chars_sent < phase_end) add_random_line();
      wait_drained();
    end

    if (errors == 0) begin
      $display("serial_motor_command_parser: match");
    end else begin
      $display("serial_motor_command_parser: mismatch");
    end
    $finish;
  end

  // ---------------- driver ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_tready) begin
      in_tvalid <= 1'b1;
    end else if (char_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
      in_tvalid <= 1'b1;
      in_tdata  <= char_q.pop_front();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      track_char(in_tdata);
      chars_taken++;
    end
  end

  // ---------------- receiver and monitor ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      taken      <= 0;
    end else begin
      if (out_tvalid && out_tready) taken <= taken + 1;
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left  <= hold_left - 1;
      end else if (out_tvalid && out_tready && (taken == 30 || taken == 150)) begin
        // long hold-off so the output register fills and the input stalls
        out_tready <= 1'b0;
        hold_left  <= HOLD_CYCLES;
      end else begin
        out_tready <= calm || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  always @(posedge clk) begin : result_check
    judge_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $error("result transfer with none expected: %h", out_tdata);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (out_tdata[2:0] != want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, out_tdata[2:0]);
          errors++;
        end
        if (out_tdata[10:3] != want.motor) begin
          $error("motor_speed: expected %0d, got %0d", want.motor, out_tdata[10:3]);
          errors++;
        end
        if (out_tdata[18:11] != want.servo) begin
          $error("servo_angle: expected %0d, got %0d", want.servo, out_tdata[18:11]);
          errors++;
        end
        if (out_tdata[19] != want.armed) begin
          $error("armed: expected %0d, got %0d", want.armed, out_tdata[19]);
          errors++;
        end
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      dead_cycles <= 0;
    end else if (dead_cycles >= STALL_LIMIT) begin
      $display("serial_motor_command_parser: mismatch");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

endmodule
